// ===== design/serial_frame_receiver_macros.svh =====
// Assertion macros used by the checker file of the serial frame receiver.
`ifndef SERIAL_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serial_frame_receiver: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("serial_frame_receiver: check failed");

`endif

// ===== design/sfr_pkg.sv =====
// Types and constants of the serial frame receiver.
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int unsigned FrameDepthDef = 16;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned IndexW        = 4;
  localparam int unsigned OutDataW      = 16;
  localparam int unsigned CfgIdxW       = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegStartByte    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAckByte      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNackByte     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegChecksumSeed = 2'd3;

  // Register reset values
  localparam logic [ByteW-1:0] StartByteRst    = 8'hB1;
  localparam logic [ByteW-1:0] AckByteRst      = 8'h06;
  localparam logic [ByteW-1:0] NackByteRst     = 8'h15;
  localparam logic [ByteW-1:0] ChecksumSeedRst = 8'hFF;

  typedef enum logic [StatusW-1:0] {
    STAT_BUSY = 3'd0,
    STAT_GOOD = 3'd1,
    STAT_ACK  = 3'd2,
    STAT_NACK = 3'd3,
    STAT_ERR  = 3'd4
  } sfr_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_CHECK,
    ST_READ
  } sfr_state_e;

endpackage

// ===== design/sfr_frame_ram.sv =====
// Frame buffer: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module sfr_frame_ram import sfr_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FrameDepthDef,
  localparam int unsigned AddrW = $clog2(FRAME_DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [ByteW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem_q [FRAME_DEPTH];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/serial_frame_receiver.sv =====
// Top level of the serial frame receiver: frame parser and readout sequencer.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata[7:0] rx_byte
//  m_axis   | out | m_axis_tvalid/tready   | tdata status,frame_byte,index; tlast
//  cfg      | in  | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// Every received byte gives one result transfer, except a good check byte,
// which starts a readout of N frame bytes from the frame buffer read port, one
// per cycle while the output is not stalled; no input is taken meanwhile.
// Outside a readout, input is taken whenever the output register is empty or being emptied.
// Reset is asynchronous, active low; the frame buffer is not cleared.
`timescale 1ns / 1ps
module serial_frame_receiver import sfr_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FrameDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] rx_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [2:0] status, [10:3] frame_byte,
                                                // [14:11] byte_index, [15] zero
  output logic                m_axis_tlast_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ByteW-1:0]    cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(FRAME_DEPTH);
  localparam int unsigned CntW  = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned CmpW  = CntW + ByteW;

  // Configuration registers
  logic [ByteW-1:0] start_byte_q, ack_byte_q, nack_byte_q, seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
      ack_byte_q   <= AckByteRst;
      nack_byte_q  <= NackByteRst;
      seed_q       <= ChecksumSeedRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStartByte:    start_byte_q <= cfg_wdata_i;
        RegAckByte:      ack_byte_q   <= cfg_wdata_i;
        RegNackByte:     nack_byte_q  <= cfg_wdata_i;
        RegChecksumSeed: seed_q       <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // Parser state
  sfr_state_e       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] acc_q, acc_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;

  // Output register
  logic              out_valid_q;
  sfr_status_e       out_status_q, out_status_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic [IndexW-1:0] out_index_q, out_index_d;
  logic              out_last_q, out_last_d;
  logic              out_load;

  // Frame buffer ports
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [ByteW-1:0] mem_rdata;

  logic             in_fire, out_free;
  logic [ByteW-1:0] rx_byte;
  logic [CntW-1:0]  count_inc;
  logic [ByteW-1:0] len_now;

  assign rx_byte   = s_axis_tdata_i;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q != ST_READ) && out_free;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign count_inc = count_q + CntW'(1);
  // The first stored byte is the length itself
  assign len_now   = (count_q == '0) ? rx_byte : len_q;

  sfr_frame_ram #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(rx_byte),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    len_d        = len_q;
    acc_d        = acc_q;
    rd_idx_d     = rd_idx_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = rd_idx_q;
    out_load     = 1'b0;
    out_status_d = STAT_BUSY;
    out_byte_d   = '0;
    out_index_d  = '0;
    out_last_d   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          if (rx_byte == start_byte_q) begin
            count_d = '0;
            acc_d   = seed_q;
            state_d = ST_DATA;
          end else if (rx_byte == ack_byte_q) begin
            out_status_d = STAT_ACK;
          end else if (rx_byte == nack_byte_q) begin
            out_status_d = STAT_NACK;
          end else begin
            out_status_d = STAT_ERR;
          end
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          out_load = 1'b1;
          if (count_q < CntW'(FRAME_DEPTH)) begin
            mem_we  = 1'b1;
            count_d = count_inc;
            if (count_q == '0) begin
              len_d = rx_byte;
            end else begin
              acc_d = acc_q ^ rx_byte;
            end
            if (CmpW'(count_inc) == CmpW'(len_now)) begin
              state_d = ST_CHECK;
            end
          end else begin
            out_status_d = STAT_ERR;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_CHECK: begin
        if (in_fire) begin
          state_d = ST_IDLE;
          if (rx_byte == acc_q) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            rd_idx_d  = '0;
            state_d   = ST_READ;
          end else begin
            out_load     = 1'b1;
            out_status_d = STAT_ERR;
          end
        end
      end
      ST_READ: begin
        // read data for rd_idx_q is in the RAM output register
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = STAT_GOOD;
          out_byte_d   = mem_rdata;
          out_index_d  = IndexW'(rd_idx_q);
          out_last_d   = (CntW'(rd_idx_q) + CntW'(1)) == count_q;
          if (out_last_d) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d  = rd_idx_q + AddrW'(1);
            mem_re    = 1'b1;
            mem_raddr = rd_idx_q + AddrW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      acc_q    <= '0;
      len_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      acc_q    <= acc_d;
      len_q    <= len_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_byte_q   <= out_byte_d;
      out_index_q  <= out_index_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_index_q, out_byte_q, out_status_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== design/sfr_checker.sv =====
// Port-level checks of the serial frame receiver, bound to the top level.
`timescale 1ns / 1ps
`include "serial_frame_receiver_macros.svh"
module sfr_checker import sfr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tlast_o
);

  logic [StatusW-1:0] out_status;
  logic [OutDataW:0]  out_word;
  logic               out_stall;
  logic               readout_mid;
  logic               single_res;
  logic               status_ok;
  logic               single_ok;

  assign out_status  = m_axis_tdata_o[2:0];
  assign out_word    = {m_axis_tlast_o, m_axis_tdata_o};
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign readout_mid = m_axis_tvalid_o && (out_status == STAT_GOOD) && !m_axis_tlast_o;
  assign single_res  = m_axis_tvalid_o && (out_status != STAT_GOOD);
  // top bit of tdata is padding
  assign status_ok   = (out_status <= STAT_ERR) && !m_axis_tdata_o[15];
  assign single_ok   = m_axis_tlast_o && (m_axis_tdata_o[14:3] == '0);

  // A stalled result holds its payload
  `SFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_word))

  // No new byte is taken while a frame readout is still running
  `SFR_ASSERT_IMPL(a_no_input_in_readout, clk_i, rst_ni, readout_mid, !s_axis_tready_o)

  // Status codes stay within the defined set and the padding bit stays zero
  `SFR_ASSERT_IMPL(a_status_range, clk_i, rst_ni, m_axis_tvalid_o, status_ok)

  // Single-result statuses carry tlast and zero byte and index
  `SFR_ASSERT_IMPL(a_single_result, clk_i, rst_ni, single_res, single_ok)

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);
